[hdl/deq_pkg.sv]
// Shared operation codes, status codes and cell control type for the deque.
`timescale 1ns / 1ps

package deq_pkg;

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int unsigned FIELD_W = 32;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_LOAD
  } cell_op_e;

endpackage

[hdl/deq_cell.sv]
// One storage cell of the deque chain: holds a word, shifts to either neighbour or loads.
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  output logic [DATA_WIDTH-1:0] word_o
);

  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] word_d;

  always_comb begin
    case (op_i)
      CELL_SHR:  word_d = left_i;
      CELL_SHL:  word_d = right_i;
      CELL_LOAD: word_d = load_i;
      default:   word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[hdl/double_ended_queue.sv]
// Bounded double-ended queue built as a row of shifting storage cells.
// The front word always sits in the first cell; a push at the front shifts the row
// towards the back and a pop at the front shifts it towards the front, while a push
// at the back loads the cell just past the last word. One transaction is taken per
// clock cycle: the result of an operation appears in the output register on the
// cycle after acceptance, and a new operation is accepted whenever that register is
// empty or is being drained in the same cycle. A full push reports overflow and an
// empty pop reports underflow, both leaving the contents untouched.
`timescale 1ns / 1ps

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W      = ((FIELD_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // push_value
  input  logic [1:0]       s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // popped_value, occupancy, zero fill
  output logic [2:0]       m_axis_tuser    // status[1:0], is_empty[2]
);

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  cell_op_e              cell_op   [DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]    popped_q, popped_d;
  logic [1:0]            status_q, status_d;
  logic [CNT_W-1:0]      occ_q;

  logic                  accept;
  logic                  full, empty;
  logic [63:0]           push_wide;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [63:0]           pop_wide;
  logic [1:0]            kind;

  assign kind          = s_axis_tuser;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(DEPTH));
  assign empty         = (count_q == '0);
  assign push_wide     = 64'(s_axis_tdata);
  assign push_word     = push_wide[DATA_WIDTH-1:0];

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_q == CNT_W'(i + 1)) back_word = back_word | cell_word[i];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_HOLD;
    count_d  = count_q;
    status_d = ST_OK;
    pop_wide = '0;
    if (accept) begin
      unique case (kind)
        KIND_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_SHR;
            count_d = count_q + 1'b1;
          end
        end
        KIND_PUSH_BACK: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (count_q == CNT_W'(i)) cell_op[i] = CELL_LOAD;
            end
            count_d = count_q + 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_SHL;
            pop_wide = 64'(cell_word[0]);
            count_d  = count_q - 1'b1;
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            pop_wide = 64'(back_word);
            count_d  = count_q - 1'b1;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
    popped_d    = pop_wide[FIELD_W-1:0];
    out_valid_d = accept || (out_valid_q && !m_axis_tready);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = push_word;
    end else begin : g_mid
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_inner
      assign right_w = cell_word[g+1];
    end
    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .load_i  (push_word),
      .word_o  (cell_word[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({occ_q, popped_q});
  assign m_axis_tuser  = {(occ_q == '0), status_q};

endmodule

[hdl/deq_checker.sv]
// Port-level checks for the deque, bound to the top level.
`timescale 1ns / 1ps

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W = ((FIELD_W + CNT_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [2:0]       m_axis_tuser
);

  logic [CNT_W-1:0] occ;
  logic [1:0]       status;

  assign occ    = m_axis_tdata[FIELD_W +: CNT_W];
  assign status = m_axis_tuser[1:0];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[2] == (occ == '0)) && (occ <= CNT_W'(DEPTH)))
    else $error("occupancy and empty flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_UNDERFLOW || status == ST_OVERFLOW)
      |-> m_axis_tdata[FIELD_W-1:0] == '0)
    else $error("failed operation returned data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == ST_UNDERFLOW |-> occ == '0)
    else $error("underflow with words stored");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
